[design/mptw_pkg.sv]
// Shared constants, codes and control types of the page table walker.
package mptw_pkg;

    localparam int NUM_FRAMES_DEF = 64;
    localparam int LEVELS_DEF     = 5;
    localparam int INDEX_BITS_DEF = 9;

    localparam int VPN_W      = 45;
    localparam int PPN_W      = 52;
    localparam int ENTRY_W    = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int ROOT_W     = 6;
    localparam int FREE_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [ROOT_W-1:0] ROOT_RESET = ROOT_W'(0);
    localparam logic [FREE_W-1:0] FREE_RESET = FREE_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PTR  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_ISSUE,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_RESULT
    } walk_state_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_READ,
        MEM_WR_LEAF,
        MEM_WR_CLEAR,
        MEM_WR_ZERO,
        MEM_WR_LINK
    } mem_op_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_HIT,
        RES_NO_FRAME,
        RES_BAD_PTR
    } res_kind_t;

    typedef struct packed {
        mem_op_t   mem_op;
        logic      load_item;
        logic      advance;
        logic      link;
        logic      alloc_latch;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      set_result;
        res_kind_t res_kind;
        logic      push;
    } walk_cmd_t;

    typedef struct packed {
        logic root_bad;
        logic last_level;
        logic is_update;
        logic entry_valid;
        logic ptr_bad;
        logic alloc_bad;
        logic sweep_last_all;
        logic sweep_last_frame;
        logic out_free;
    } walk_stat_t;

endpackage

[design/multilevel_page_table_walker_unit.sv]
// Top level of the multilevel page table walker: controller and datapath.
//
// Input channel (in_valid/in_stall, fields kind, vpn, ppn, unmap) takes one query or
// update at a time; the output channel (out_valid/out_stall, fields mapped, ppn_out,
// status) returns exactly one transfer per accepted item.
// A query passes through the start state, then a read (S_ISSUE) and an evaluate (S_EVAL)
// state per level, the result state that hands the result to the output register and the
// idle state. A query that meets an invalid inner entry ends early. An update writes the
// leaf from the read state of the last level; for each table frame it allocates, the new
// frame is zeroed one entry per cycle through the single store port before it is linked.
// The table store read is registered, so a read state comes before each evaluate state.
// After reset the store is cleared one entry per cycle; in_stall stays high meanwhile,
// while configuration writes on cfg_we/cfg_index/cfg_data are taken at any time.
// Results sit in an output register; while out_stall is high the result holds and a
// finished walk waits for the register to free before the next item is taken.
module multilevel_page_table_walker_unit #(
    parameter int NUM_FRAMES = mptw_pkg::NUM_FRAMES_DEF,
    parameter int LEVELS     = mptw_pkg::LEVELS_DEF,
    parameter int INDEX_BITS = mptw_pkg::INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mptw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [mptw_pkg::VPN_W-1:0]      vpn,
    input  logic [mptw_pkg::PPN_W-1:0]      ppn,
    input  logic                            unmap,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            mapped,
    output logic [mptw_pkg::PPN_W-1:0]      ppn_out,
    output logic [mptw_pkg::STATUS_W-1:0]   status
);

    mptw_pkg::walk_cmd_t  cmd;
    mptw_pkg::walk_stat_t stat;

    mptw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mptw_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .LEVELS     (LEVELS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .vpn       (vpn),
        .ppn       (ppn),
        .unmap     (unmap),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .mapped    (mapped),
        .ppn_out   (ppn_out),
        .status    (status)
    );

endmodule

[design/mptw_datapath.sv]
// Datapath of the walker: table store, walk registers, allocator and result registers.
module mptw_datapath #(
    parameter int NUM_FRAMES = mptw_pkg::NUM_FRAMES_DEF,
    parameter int LEVELS     = mptw_pkg::LEVELS_DEF,
    parameter int INDEX_BITS = mptw_pkg::INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mptw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mptw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                kind,
    input  logic [mptw_pkg::VPN_W-1:0]          vpn,
    input  logic [mptw_pkg::PPN_W-1:0]          ppn,
    input  logic                                unmap,
    input  logic                                out_stall,
    input  mptw_pkg::walk_cmd_t                 cmd,
    output mptw_pkg::walk_stat_t                stat,
    output logic                                out_valid,
    output logic                                mapped,
    output logic [mptw_pkg::PPN_W-1:0]          ppn_out,
    output logic [mptw_pkg::STATUS_W-1:0]       status
);

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int ADDR_W  = FRAME_W + INDEX_BITS;
    localparam int DEPTH   = NUM_FRAMES * (2 ** INDEX_BITS);
    localparam int WALK_W  = LEVELS * INDEX_BITS;
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int FU_W    = $clog2(NUM_FRAMES + 1);
    localparam int SUM_W   = ((FU_W > mptw_pkg::FREE_W) ? FU_W : mptw_pkg::FREE_W) + 1;
    localparam int LOW_W   = mptw_pkg::PAGE_SHIFT - 1;

    logic [mptw_pkg::ENTRY_W-1:0]  store_mem [DEPTH];
    logic [mptw_pkg::ENTRY_W-1:0]  rd_data_reg;

    logic [mptw_pkg::ROOT_W-1:0]   root_frame_reg;
    logic [mptw_pkg::FREE_W-1:0]   first_free_reg;
    logic                          update_reg;
    logic                          unmap_reg;
    logic [mptw_pkg::PPN_W-1:0]    ppn_reg;
    logic [WALK_W-1:0]             walk_reg;
    logic [LVL_W-1:0]              level_reg;
    logic [FRAME_W-1:0]            frame_reg;
    logic [FRAME_W-1:0]            alloc_frame_reg;
    logic [FU_W-1:0]               frames_used_reg;
    logic [ADDR_W-1:0]             sweep_reg;

    logic                          res_mapped_reg;
    logic [mptw_pkg::PPN_W-1:0]    res_ppn_reg;
    logic [mptw_pkg::STATUS_W-1:0] res_status_reg;
    logic                          out_valid_reg;
    logic                          out_mapped_reg;
    logic [mptw_pkg::PPN_W-1:0]    out_ppn_reg;
    logic [mptw_pkg::STATUS_W-1:0] out_status_reg;

    logic [INDEX_BITS-1:0]         slice;
    logic [ADDR_W-1:0]             mem_addr;
    logic [mptw_pkg::ENTRY_W-1:0]  mem_wdata;
    logic                          mem_we;
    logic                          mem_re;
    logic [mptw_pkg::PPN_W-1:0]    ptr;
    logic [SUM_W-1:0]              alloc_sum;

    // The walk register holds the remaining index slices, the current one on top.
    assign slice     = walk_reg[WALK_W-1 -: INDEX_BITS];
    assign ptr       = rd_data_reg[mptw_pkg::ENTRY_W-1:mptw_pkg::PAGE_SHIFT];
    assign alloc_sum = SUM_W'(first_free_reg) + SUM_W'(frames_used_reg);

    always_comb
    begin
        mem_addr  = {frame_reg, slice};
        mem_wdata = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        unique case (cmd.mem_op)
            mptw_pkg::MEM_READ:
            begin
                mem_re = 1'b1;
            end
            mptw_pkg::MEM_WR_LEAF:
            begin
                mem_we = 1'b1;
                if (!unmap_reg)
                begin
                    mem_wdata = {ppn_reg, {LOW_W{1'b0}}, 1'b1};
                end
            end
            mptw_pkg::MEM_WR_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = sweep_reg;
            end
            mptw_pkg::MEM_WR_ZERO:
            begin
                mem_we   = 1'b1;
                mem_addr = {alloc_frame_reg, sweep_reg[INDEX_BITS-1:0]};
            end
            mptw_pkg::MEM_WR_LINK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {mptw_pkg::PPN_W'(alloc_frame_reg), {LOW_W{1'b0}}, 1'b1};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= mptw_pkg::ROOT_RESET;
            first_free_reg <= mptw_pkg::FREE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mptw_pkg::CFG_ROOT_FRAME)
            begin
                root_frame_reg <= cfg_data[mptw_pkg::ROOT_W-1:0];
            end
            else if (cfg_index == mptw_pkg::CFG_FIRST_FREE)
            begin
                first_free_reg <= cfg_data[mptw_pkg::FREE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            frames_used_reg <= '0;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                level_reg <= LVL_W'(1);
            end
            else if (cmd.advance || cmd.link)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end

            if (cmd.link)
            begin
                frames_used_reg <= frames_used_reg + FU_W'(1);
            end

            if (cmd.sweep_clr)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            update_reg <= kind;
            unmap_reg  <= unmap;
            ppn_reg    <= ppn;
            walk_reg   <= WALK_W'(vpn);
            frame_reg  <= FRAME_W'(root_frame_reg);
        end
        else if (cmd.advance)
        begin
            walk_reg  <= walk_reg << INDEX_BITS;
            frame_reg <= FRAME_W'(ptr);
        end
        else if (cmd.link)
        begin
            walk_reg  <= walk_reg << INDEX_BITS;
            frame_reg <= alloc_frame_reg;
        end

        if (cmd.alloc_latch)
        begin
            alloc_frame_reg <= FRAME_W'(alloc_sum);
        end

        if (cmd.set_result)
        begin
            unique case (cmd.res_kind)
                mptw_pkg::RES_HIT:
                begin
                    res_mapped_reg <= 1'b1;
                    res_ppn_reg    <= ptr;
                    res_status_reg <= mptw_pkg::STATUS_OK;
                end
                mptw_pkg::RES_NO_FRAME:
                begin
                    res_mapped_reg <= 1'b0;
                    res_ppn_reg    <= '0;
                    res_status_reg <= mptw_pkg::STATUS_NO_FRAME;
                end
                mptw_pkg::RES_BAD_PTR:
                begin
                    res_mapped_reg <= 1'b0;
                    res_ppn_reg    <= '0;
                    res_status_reg <= mptw_pkg::STATUS_BAD_PTR;
                end
                default:
                begin
                    res_mapped_reg <= 1'b0;
                    res_ppn_reg    <= '0;
                    res_status_reg <= mptw_pkg::STATUS_OK;
                end
            endcase
        end

        if (cmd.push)
        begin
            out_mapped_reg <= res_mapped_reg;
            out_ppn_reg    <= res_ppn_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        stat.root_bad         = 32'(root_frame_reg) >= 32'(NUM_FRAMES);
        stat.last_level       = level_reg == LVL_W'(LEVELS);
        stat.is_update        = update_reg;
        stat.entry_valid      = rd_data_reg[0];
        stat.ptr_bad          = ptr >= mptw_pkg::PPN_W'(NUM_FRAMES);
        stat.alloc_bad        = 32'(alloc_sum) >= 32'(NUM_FRAMES);
        stat.sweep_last_all   = sweep_reg == ADDR_W'(DEPTH - 1);
        stat.sweep_last_frame = &sweep_reg[INDEX_BITS-1:0];
        stat.out_free         = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign mapped    = out_mapped_reg;
    assign ppn_out   = out_ppn_reg;
    assign status    = out_status_reg;

endmodule

[design/mptw_ctrl.sv]
// Controller state machine that sequences clearing, walking, allocation and result transfer.
module mptw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mptw_pkg::walk_stat_t stat,
    output mptw_pkg::walk_cmd_t  cmd
);

    mptw_pkg::walk_state_t state_reg;
    mptw_pkg::walk_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mptw_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mptw_pkg::S_CLEAR:
            begin
                if (stat.sweep_last_all)
                begin
                    state_next = mptw_pkg::S_IDLE;
                end
            end
            mptw_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mptw_pkg::S_START;
                end
            end
            mptw_pkg::S_START:
            begin
                state_next = stat.root_bad ? mptw_pkg::S_RESULT : mptw_pkg::S_ISSUE;
            end
            mptw_pkg::S_ISSUE:
            begin
                if (stat.last_level && stat.is_update)
                begin
                    state_next = mptw_pkg::S_RESULT;
                end
                else
                begin
                    state_next = mptw_pkg::S_EVAL;
                end
            end
            mptw_pkg::S_EVAL:
            begin
                if (stat.last_level)
                begin
                    state_next = mptw_pkg::S_RESULT;
                end
                else if (stat.entry_valid)
                begin
                    state_next = stat.ptr_bad ? mptw_pkg::S_RESULT : mptw_pkg::S_ISSUE;
                end
                else if (!stat.is_update || stat.alloc_bad)
                begin
                    state_next = mptw_pkg::S_RESULT;
                end
                else
                begin
                    state_next = mptw_pkg::S_ZERO;
                end
            end
            mptw_pkg::S_ZERO:
            begin
                if (stat.sweep_last_frame)
                begin
                    state_next = mptw_pkg::S_LINK;
                end
            end
            mptw_pkg::S_LINK:
            begin
                state_next = mptw_pkg::S_ISSUE;
            end
            mptw_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = mptw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mptw_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mem_op   = mptw_pkg::MEM_NONE;
        cmd.res_kind = mptw_pkg::RES_OK;
        in_stall     = 1'b1;
        unique case (state_reg)
            mptw_pkg::S_CLEAR:
            begin
                cmd.mem_op    = mptw_pkg::MEM_WR_CLEAR;
                cmd.sweep_inc = 1'b1;
                cmd.sweep_clr = stat.sweep_last_all;
            end
            mptw_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            mptw_pkg::S_START:
            begin
                if (stat.root_bad)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = mptw_pkg::RES_BAD_PTR;
                end
            end
            mptw_pkg::S_ISSUE:
            begin
                if (stat.last_level && stat.is_update)
                begin
                    cmd.mem_op     = mptw_pkg::MEM_WR_LEAF;
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = mptw_pkg::RES_OK;
                end
                else
                begin
                    cmd.mem_op = mptw_pkg::MEM_READ;
                end
            end
            mptw_pkg::S_EVAL:
            begin
                if (stat.last_level)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = stat.entry_valid ? mptw_pkg::RES_HIT : mptw_pkg::RES_OK;
                end
                else if (stat.entry_valid)
                begin
                    if (stat.ptr_bad)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_kind   = mptw_pkg::RES_BAD_PTR;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else if (!stat.is_update)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = mptw_pkg::RES_OK;
                end
                else if (stat.alloc_bad)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = mptw_pkg::RES_NO_FRAME;
                end
                else
                begin
                    cmd.alloc_latch = 1'b1;
                    cmd.sweep_clr   = 1'b1;
                end
            end
            mptw_pkg::S_ZERO:
            begin
                cmd.mem_op    = mptw_pkg::MEM_WR_ZERO;
                cmd.sweep_inc = 1'b1;
            end
            mptw_pkg::S_LINK:
            begin
                // The link is written after the zero sweep, so it survives even when
                // the new frame is the one that holds the link.
                cmd.mem_op = mptw_pkg::MEM_WR_LINK;
                cmd.link   = 1'b1;
            end
            mptw_pkg::S_RESULT:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the five-level page table walker: directed walks, then random traffic.
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAMES       = mptw_pkg::NUM_FRAMES_DEF;
    localparam int LVLS         = mptw_pkg::LEVELS_DEF;
    localparam int IDXB         = mptw_pkg::INDEX_BITS_DEF;
    localparam int SLOTS        = FRAMES << IDXB;
    localparam int WALK_LATENCY = 2 * LVLS + 3;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int POOL_DEPTH   = 32;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;
    localparam logic [mptw_pkg::ENTRY_W-1:0] PTE_VALID = mptw_pkg::ENTRY_W'(1);

    typedef struct {
        logic                          mapped;
        logic [mptw_pkg::PPN_W-1:0]    ppn_out;
        logic [mptw_pkg::STATUS_W-1:0] status;
    } walk_outcome_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mptw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mptw_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic                            kind;
    logic [mptw_pkg::VPN_W-1:0]      vpn;
    logic [mptw_pkg::PPN_W-1:0]      ppn;
    logic                            unmap;
    logic                            out_valid;
    logic                            out_stall;
    logic                            mapped;
    logic [mptw_pkg::PPN_W-1:0]      ppn_out;
    logic [mptw_pkg::STATUS_W-1:0]   status;

    // Mirror of the block's table store, allocator and registers.
    logic [mptw_pkg::ENTRY_W-1:0] pte_mirror [SLOTS];
    int                           frames_used_mirror;
    logic [mptw_pkg::ROOT_W-1:0]  root_mirror;
    logic [mptw_pkg::FREE_W-1:0]  free_mirror;

    walk_outcome_t                walk_expect[$];
    logic [mptw_pkg::VPN_W-1:0]   vpn_pool[$];
    int                           mismatches = 0;
    bit                           tx_idle_on = 1'b0;
    bit                           rx_idle_on = 1'b0;
    int                           rx_hold_len = 0;

    multilevel_page_table_walker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .vpn       (vpn),
        .ppn       (ppn),
        .unmap     (unmap),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mapped    (mapped),
        .ppn_out   (ppn_out),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_walk(input logic k, input logic [mptw_pkg::VPN_W-1:0] v,
                                         input logic [mptw_pkg::PPN_W-1:0] p, input logic u);
        walk_outcome_t                res;
        logic [mptw_pkg::ENTRY_W-1:0] ent;
        logic [mptw_pkg::PPN_W-1:0]   frame;
        int                           slot;
        int                           nf;
        res.mapped  = 1'b0;
        res.ppn_out = '0;
        res.status  = mptw_pkg::STATUS_OK;
        frame = mptw_pkg::PPN_W'(root_mirror);
        if (frame >= FRAMES)
        begin
            res.status = mptw_pkg::STATUS_BAD_PTR;
            walk_expect.push_back(res);
            return;
        end
        for (int lvl = 1; lvl < LVLS; lvl++)
        begin
            slot = (int'(frame) << IDXB) | int'(v[(LVLS - lvl) * IDXB +: IDXB]);
            ent = pte_mirror[slot];
            if (!ent[0])
            begin
                if (k == KIND_QUERY)
                begin
                    walk_expect.push_back(res);
                    return;
                end
                nf = int'(free_mirror) + frames_used_mirror;
                if (nf >= FRAMES)
                begin
                    res.status = mptw_pkg::STATUS_NO_FRAME;
                    walk_expect.push_back(res);
                    return;
                end
                // The new table is cleared even if that frame is still linked elsewhere.
                for (int s = 0; s < (1 << IDXB); s++)
                    pte_mirror[(nf << IDXB) | s] = '0;
                frames_used_mirror++;
                ent = (mptw_pkg::ENTRY_W'(nf) << mptw_pkg::PAGE_SHIFT) | PTE_VALID;
                pte_mirror[slot] = ent;
            end
            frame = ent[mptw_pkg::ENTRY_W-1:mptw_pkg::PAGE_SHIFT];
            if (frame >= FRAMES)
            begin
                res.status = mptw_pkg::STATUS_BAD_PTR;
                walk_expect.push_back(res);
                return;
            end
        end
        slot = (int'(frame) << IDXB) | int'(v[IDXB-1:0]);
        if (k == KIND_UPDATE)
            pte_mirror[slot] = u ? '0 : ({p, {mptw_pkg::PAGE_SHIFT{1'b0}}} | PTE_VALID);
        else if (pte_mirror[slot][0])
        begin
            res.mapped  = 1'b1;
            res.ppn_out = pte_mirror[slot][mptw_pkg::ENTRY_W-1:mptw_pkg::PAGE_SHIFT];
        end
        walk_expect.push_back(res);
    endfunction

    // Frame of the last-level table on the path of v, or -1 if the path is incomplete or points past the last frame.
    function automatic int leaf_table_of(input logic [mptw_pkg::VPN_W-1:0] v);
        logic [mptw_pkg::ENTRY_W-1:0] ent;
        int                           frame;
        frame = int'(root_mirror);
        for (int lvl = 1; lvl < LVLS; lvl++)
        begin
            ent = pte_mirror[(frame << IDXB) | int'(v[(LVLS - lvl) * IDXB +: IDXB])];
            if (!ent[0] || ent[mptw_pkg::ENTRY_W-1:mptw_pkg::PAGE_SHIFT] >= FRAMES)
                return -1;
            frame = int'(ent[mptw_pkg::ENTRY_W-1:mptw_pkg::PAGE_SHIFT]);
        end
        return frame;
    endfunction

    // Mostly addresses that share a path with earlier updates, so walks get deep.
    function automatic logic [mptw_pkg::VPN_W-1:0] pick_vpn();
        logic [mptw_pkg::VPN_W-1:0] base;
        logic [mptw_pkg::VPN_W-1:0] noise;
        noise = mptw_pkg::VPN_W'({$urandom, $urandom});
        if (vpn_pool.size() == 0)
            return noise;
        base = vpn_pool[$urandom_range(0, vpn_pool.size() - 1)];
        case ($urandom_range(0, 9))
            0, 1:    return noise;
            2, 3, 4: return base;
            5, 6:    return {base[mptw_pkg::VPN_W-1:IDXB], noise[IDXB-1:0]};
            7:       return {base[mptw_pkg::VPN_W-1:3*IDXB], noise[3*IDXB-1:0]};
            default: return {base[IDXB-1:0], noise[mptw_pkg::VPN_W-IDXB-1:0]};
        endcase
    endfunction

    function automatic logic [mptw_pkg::PPN_W-1:0] pick_ppn();
        case ($urandom_range(0, 3))
            0:       return mptw_pkg::PPN_W'($urandom_range(0, FRAMES - 1));
            1:       return $urandom_range(0, 1) ? {mptw_pkg::PPN_W{1'b1}}
                                                 : {mptw_pkg::PPN_W{1'b0}};
            default: return mptw_pkg::PPN_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic write_reg(input logic [mptw_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [mptw_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == mptw_pkg::CFG_ROOT_FRAME)
            root_mirror = val[mptw_pkg::ROOT_W-1:0];
        else if (idx == mptw_pkg::CFG_FIRST_FREE)
            free_mirror = val[mptw_pkg::FREE_W-1:0];
    endtask

    task automatic set_root(input int f);
        write_reg(mptw_pkg::CFG_ROOT_FRAME,
                  mptw_pkg::CFG_DATA_W'({1'($urandom_range(0, 1)), mptw_pkg::ROOT_W'(f)}));
    endtask

    task automatic set_first_free(input int f);
        write_reg(mptw_pkg::CFG_FIRST_FREE, mptw_pkg::CFG_DATA_W'(f));
    endtask

    // Valid stays high after a transfer; it drops only for a gap or a drain.
    task automatic send_walk(input logic k, input logic [mptw_pkg::VPN_W-1:0] v,
                             input logic [mptw_pkg::PPN_W-1:0] p, input logic u);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        vpn      <= v;
        ppn      <= p;
        unmap    <= u;
        do @(posedge clk); while (in_stall);
        predict_walk(k, v, p, u);
    endtask

    task automatic send_random_walk();
        logic                       k;
        logic [mptw_pkg::VPN_W-1:0] v;
        k = 1'($urandom_range(0, 1));
        v = pick_vpn();
        if (k == KIND_UPDATE)
        begin
            vpn_pool.push_back(v);
            if (vpn_pool.size() > POOL_DEPTH)
                vpn_pool.delete(0);
        end
        send_walk(k, v, pick_ppn(), $urandom_range(0, 4) == 0);
    endtask

    task automatic drain_walks();
        in_valid <= 1'b0;
        do @(posedge clk); while (walk_expect.size() != 0);
    endtask

    task automatic test_directed_walks();
        logic [mptw_pkg::VPN_W-1:0] far;
        logic [mptw_pkg::VPN_W-1:0] fresh;
        far   = {mptw_pkg::VPN_W{1'b1}};
        fresh = {IDXB'(9'h0AA), 36'(mptw_pkg::VPN_W'({$urandom, $urandom}))};
        set_root(0);
        set_first_free(1);
        send_walk(KIND_QUERY, '0, '0, 1'b0);
        send_walk(KIND_QUERY, far, {mptw_pkg::PPN_W{1'b1}}, 1'b1);
        send_walk(KIND_UPDATE, far, {mptw_pkg::PPN_W{1'b1}}, 1'b0);
        send_walk(KIND_QUERY, far, '0, 1'b0);
        // A leaf that maps page zero is still a valid mapping.
        send_walk(KIND_UPDATE, '0, '0, 1'b0);
        send_walk(KIND_QUERY, '0, {mptw_pkg::PPN_W{1'b1}}, 1'b0);
        send_walk(KIND_UPDATE, far ^ mptw_pkg::VPN_W'(1), mptw_pkg::PPN_W'(5), 1'b0);
        send_walk(KIND_QUERY, far ^ mptw_pkg::VPN_W'(1), '0, 1'b0);
        send_walk(KIND_UPDATE, far, pick_ppn(), 1'b1);
        send_walk(KIND_QUERY, far, '0, 1'b0);
        send_walk(KIND_QUERY, far ^ (mptw_pkg::VPN_W'(1) << (3 * IDXB)), '0, 1'b0);
        // Unmapping an address never mapped still builds its inner tables.
        send_walk(KIND_UPDATE, fresh, pick_ppn(), 1'b1);
        send_walk(KIND_QUERY, fresh, '0, 1'b0);
        vpn_pool.push_back(far);
        vpn_pool.push_back('0);
        vpn_pool.push_back(fresh);
        drain_walks();
    endtask

    // Rooting the walk at a last-level table makes leaf entries act as table pointers.
    task automatic test_bad_pointer();
        logic [mptw_pkg::VPN_W-1:0] far;
        logic [mptw_pkg::VPN_W-1:0] noise;
        int                         leaf;
        far   = {mptw_pkg::VPN_W{1'b1}};
        noise = mptw_pkg::VPN_W'({$urandom, $urandom});
        send_walk(KIND_UPDATE, far ^ mptw_pkg::VPN_W'(2), {mptw_pkg::PPN_W{1'b1}}, 1'b0);
        drain_walks();
        leaf = leaf_table_of(far);
        set_root(leaf < 0 ? 0 : leaf);
        send_walk(KIND_QUERY, {far[IDXB-1:0] ^ IDXB'(2), noise[mptw_pkg::VPN_W-IDXB-1:0]},
                  '0, 1'b0);
        send_walk(KIND_UPDATE, {far[IDXB-1:0] ^ IDXB'(2), noise[mptw_pkg::VPN_W-IDXB-1:0]},
                  pick_ppn(), 1'b0);
        send_walk(KIND_QUERY, {far[IDXB-1:0] ^ IDXB'(1), noise[mptw_pkg::VPN_W-IDXB-1:0]},
                  '0, 1'b0);
        send_walk(KIND_UPDATE, {IDXB'(0), noise[mptw_pkg::VPN_W-IDXB-1:0]}, pick_ppn(), 1'b0);
        drain_walks();
        set_root(0);
        send_walk(KIND_QUERY, {far[mptw_pkg::VPN_W-1:IDXB], IDXB'(0)}, '0, 1'b0);
        drain_walks();
    endtask

    task automatic test_frame_limits();
        logic [mptw_pkg::VPN_W-1:0] v;
        int                         ff;
        set_first_free(FRAMES);
        v = mptw_pkg::VPN_W'({$urandom, $urandom});
        send_walk(KIND_UPDATE, v, pick_ppn(), 1'b0);
        send_walk(KIND_QUERY, v, '0, 1'b0);
        drain_walks();
        // Allocation now lands on frames that are already part of the tree.
        set_first_free(0);
        send_walk(KIND_UPDATE, mptw_pkg::VPN_W'({$urandom, $urandom}), pick_ppn(), 1'b0);
        send_walk(KIND_QUERY, {mptw_pkg::VPN_W{1'b1}} ^ mptw_pkg::VPN_W'(1), '0, 1'b0);
        send_walk(KIND_QUERY, '0, '0, 1'b0);
        drain_walks();
        // Leave room for exactly two tables so the next fresh update runs dry mid-walk.
        ff = FRAMES - 2 - frames_used_mirror;
        set_first_free(ff < 0 ? 0 : ff);
        v = mptw_pkg::VPN_W'({$urandom, $urandom});
        send_walk(KIND_UPDATE, v, pick_ppn(), 1'b0);
        send_walk(KIND_QUERY, v, '0, 1'b0);
        send_walk(KIND_UPDATE, {v[mptw_pkg::VPN_W-1:3*IDXB], 27'($urandom)}, pick_ppn(), 1'b0);
        drain_walks();
    endtask

    task automatic test_output_backpressure();
        rx_hold_len = 200;
        repeat (16) send_random_walk();
        drain_walks();
        repeat (8) send_random_walk();
        drain_walks();
    endtask

    task automatic test_random_walks();
        int root_pick;
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 6)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: root_pick = 0;
                1: root_pick = leaf_table_of(vpn_pool[$urandom_range(0, vpn_pool.size() - 1)]);
                2: root_pick = $urandom_range(0, FRAMES - 1);
                default: root_pick = FRAMES - 1;
            endcase
            if (phase == 0 || root_pick < 0)
                root_pick = 0;
            set_root(root_pick);
            if (phase == 0)
                set_first_free(0);
            else if (phase == 3)
                set_first_free(FRAMES);
            else
                set_first_free($urandom_range(0, 24));
            repeat (240) send_random_walk();
            drain_walks();
        end
    endtask

    always @(posedge clk)
    begin : check_result
        walk_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (walk_expect.size() == 0)
            begin
                $error("result transfer with no walk outstanding, status %0d", status);
                mismatches++;
            end
            else
            begin
                want = walk_expect.pop_front();
                if (mapped !== want.mapped)
                begin
                    $error("mapped: expected %0d, got %0d", want.mapped, mapped);
                    mismatches++;
                end
                if (ppn_out !== want.ppn_out)
                begin
                    $error("ppn_out: expected %0h, got %0h", want.ppn_out, ppn_out);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                hold = rx_hold_len;
                rx_hold_len = 0;
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        for (int cycle = 0; cycle < CYCLE_LIMIT; cycle++)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        kind      <= 1'b0;
        vpn       <= '0;
        ppn       <= '0;
        unmap     <= 1'b0;
        for (int s = 0; s < SLOTS; s++)
            pte_mirror[s] = '0;
        frames_used_mirror = 0;
        root_mirror        = mptw_pkg::ROOT_RESET;
        free_mirror        = mptw_pkg::FREE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_directed_walks();
        test_bad_pointer();
        test_frame_limits();
        test_output_backpressure();
        test_random_walks();
        drain_walks();
        repeat (WALK_LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
